### rtl/ppm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and register codes for the projective pixel map.
// Used by ppm_lin, ppm_div and projective_pixel_map_core; depends on nothing.
package ppm_pkg;

	localparam int COORD_W = 12;
	localparam int COEF_W  = 32;
	localparam int PROD_W  = COEF_W + COORD_W + 1;
	localparam int SUM_W   = PROD_W + 2;
	localparam int MAG_W   = SUM_W;
	localparam int REM_W   = MAG_W + 3;
	localparam int QUO_W   = 32;
	localparam int STEPS   = 2;
	localparam int NSTAGE  = QUO_W / STEPS;
	localparam int IDX_W   = 8;
	localparam int NUM_REGS = 8;

	localparam logic [IDX_W-1:0] REG_COEF_A  = 8'd0;
	localparam logic [IDX_W-1:0] REG_COEF_B  = 8'd1;
	localparam logic [IDX_W-1:0] REG_COEF_C  = 8'd2;
	localparam logic [IDX_W-1:0] REG_COEF_D  = 8'd3;
	localparam logic [IDX_W-1:0] REG_COEF_E  = 8'd4;
	localparam logic [IDX_W-1:0] REG_COEF_F  = 8'd5;
	localparam logic [IDX_W-1:0] REG_PERSP_G = 8'd6;
	localparam logic [IDX_W-1:0] REG_PERSP_H = 8'd7;

	localparam logic signed [COEF_W-1:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [SUM_W-1:0]  ONE_Q30 = SUM_W'(64'sd1073741824);

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] e;
		logic signed [COEF_W-1:0] f;
		logic signed [COEF_W-1:0] g;
		logic signed [COEF_W-1:0] h;
	} coef_t;

	// One restoring division step: shift the partial remainder, then
	// subtract the scaled divisor when it fits. Bit 0 is the quotient bit.
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
			input logic [REM_W-1:0] dvs);
		logic [REM_W-1:0] sh;
		sh = {rem[REM_W-2:0], 1'b0};
		if (sh >= dvs) begin
			div_step = {sh - dvs, 1'b1};
		end else begin
			div_step = {sh, 1'b0};
		end
	endfunction

endpackage

### rtl/ppm_lin.sv
`timescale 1ns / 1ps
// Two-stage evaluation of the three linear forms X, Y and W.
// Depends on ppm_pkg.
module ppm_lin (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [ppm_pkg::COORD_W-1:0]         col,
	input  logic [ppm_pkg::COORD_W-1:0]         row,
	input  ppm_pkg::coef_t                      coef,
	output logic                                out_vld,
	output logic signed [ppm_pkg::SUM_W-1:0]    sum_x,
	output logic signed [ppm_pkg::SUM_W-1:0]    sum_y,
	output logic signed [ppm_pkg::SUM_W-1:0]    sum_w
);
	import ppm_pkg::*;

	logic signed [COORD_W:0] col_sx, row_sx;
	logic signed [PROD_W-1:0] pa_s1, pb_s1, pd_s1, pe_s1, pg_s1, ph_s1;
	logic signed [COEF_W-1:0] c_s1, f_s1;
	logic vld_s1, vld_s2;
	logic signed [SUM_W-1:0] x_s2, y_s2, w_s2;

	assign col_sx = {1'b0, col};
	assign row_sx = {1'b0, row};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pa_s1 <= coef.a * col_sx;
		pb_s1 <= coef.b * row_sx;
		pd_s1 <= coef.d * col_sx;
		pe_s1 <= coef.e * row_sx;
		pg_s1 <= coef.g * col_sx;
		ph_s1 <= coef.h * row_sx;
		c_s1  <= coef.c;
		f_s1  <= coef.f;
		x_s2  <= SUM_W'(pa_s1) + SUM_W'(pb_s1) + SUM_W'(c_s1);
		y_s2  <= SUM_W'(pd_s1) + SUM_W'(pe_s1) + SUM_W'(f_s1);
		w_s2  <= SUM_W'(pg_s1) + SUM_W'(ph_s1) + ONE_Q30;
	end

	assign out_vld = vld_s2;
	assign sum_x   = x_s2;
	assign sum_y   = y_s2;
	assign sum_w   = w_s2;

endmodule

### rtl/ppm_div.sv
`timescale 1ns / 1ps
// Pipelined signed fixed-point divider: trunc(num * 2^30 / den), saturated.
// Two quotient bits per stage. Depends on ppm_pkg.
module ppm_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic signed [ppm_pkg::SUM_W-1:0]   num,
	input  logic signed [ppm_pkg::SUM_W-1:0]   den,
	output logic                               out_vld,
	output logic signed [ppm_pkg::QUO_W-1:0]   quo,
	output logic                               den_zero
);
	import ppm_pkg::*;

	// Magnitude stage.
	logic vld_sa, neg_sa, zero_sa;
	logic [MAG_W-1:0] n_sa, d_sa;
	// Range check stage.
	logic vld_sb, neg_sb, zero_sb, ovf_sb;
	// Iteration stages, index 0 is the range check stage.
	logic [REM_W-1:0] rem_s [0:NSTAGE];
	logic [REM_W-1:0] dvs_s [0:NSTAGE];
	logic [QUO_W-1:0] q_s   [0:NSTAGE];
	logic [NSTAGE:0]  vld_s, neg_s, zero_s, ovf_s;
	// Output stage.
	logic vld_so, zero_so;
	logic signed [QUO_W-1:0] quo_so;
	logic [QUO_W:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_sb <= 1'b0;
			vld_so <= 1'b0;
		end else begin
			vld_sa <= in_vld;
			vld_sb <= vld_sa;
			vld_so <= vld_s[NSTAGE];
		end
	end

	always_ff @(posedge clk) begin
		neg_sa  <= num[SUM_W-1] ^ den[SUM_W-1];
		zero_sa <= (den == '0);
		n_sa    <= num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
		d_sa    <= den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
		neg_sb  <= neg_sa;
		zero_sb <= zero_sa;
		ovf_sb  <= {2'b00, n_sa} >= {d_sa, 2'b00};
		rem_s[0] <= REM_W'(n_sa);
		dvs_s[0] <= REM_W'({d_sa, 2'b00});
	end

	assign vld_s[0]  = vld_sb;
	assign neg_s[0]  = neg_sb;
	assign zero_s[0] = zero_sb;
	assign ovf_s[0]  = ovf_sb;
	assign q_s[0]    = '0;

	for (genvar k = 1; k <= NSTAGE; k++) begin : g_stage
		logic [REM_W:0] st1, st2;
		assign st1 = div_step(rem_s[k-1], dvs_s[k-1]);
		assign st2 = div_step(st1[REM_W:1], dvs_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= st2[REM_W:1];
			dvs_s[k]  <= dvs_s[k-1];
			q_s[k]    <= {q_s[k-1][QUO_W-3:0], st1[0], st2[0]};
			neg_s[k]  <= neg_s[k-1];
			zero_s[k] <= zero_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
		end
	end

	assign mag = ovf_s[NSTAGE] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, q_s[NSTAGE]};

	always_ff @(posedge clk) begin
		zero_so <= zero_s[NSTAGE];
		if (zero_s[NSTAGE]) begin
			quo_so <= '0;
		end else if (neg_s[NSTAGE]) begin
			if (mag >= {2'b01, {(QUO_W-1){1'b0}}}) begin
				quo_so <= {1'b1, {(QUO_W-1){1'b0}}};
			end else begin
				quo_so <= QUO_W'(-mag);
			end
		end else if (mag > {2'b00, {(QUO_W-1){1'b1}}}) begin
			quo_so <= {1'b0, {(QUO_W-1){1'b1}}};
		end else begin
			quo_so <= QUO_W'(mag);
		end
	end

	assign out_vld  = vld_so;
	assign quo      = quo_so;
	assign den_zero = zero_so;

endmodule

### rtl/projective_pixel_map_core.sv
`timescale 1ns / 1ps
// Top level of the projective pixel map: configuration registers, input
// clamp, linear forms and two dividers. Depends on ppm_pkg, ppm_lin, ppm_div.
//
// One item (pix_col, pix_row) may be started in every clock cycle; busy is
// never raised. Each item yields exactly one result, shown on map_x, map_y
// and w_zero for the single cycle in which done is high. Between start and
// done lie the input clamp register, the linear-form stages and the stages of
// each divider, whose number is set by two quotient bits per stage over 32
// quotient bits. The receiver cannot hold results off, so results leave in
// start order with no gaps added. Coefficient writes are always accepted
// (cfg_ready is high) and must only be made while no item is in flight.
module projective_pixel_map_core #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [ppm_pkg::COORD_W-1:0]           pix_col,
	input  logic [ppm_pkg::COORD_W-1:0]           pix_row,
	output logic                                  done,
	output logic signed [ppm_pkg::QUO_W-1:0]      map_x,
	output logic signed [ppm_pkg::QUO_W-1:0]      map_y,
	output logic                                  w_zero,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ppm_pkg::IDX_W-1:0]             cfg_index,
	input  logic [ppm_pkg::COEF_W-1:0]            cfg_data
);
	import ppm_pkg::*;

	// Largest legal coordinate; coordinates above it are clamped.
	localparam logic [COORD_W-1:0] COORD_LIM =
		(MAX_DIM - 1 > (1 << COORD_W) - 1) ? {COORD_W{1'b1}} : COORD_W'(MAX_DIM - 1);

	coef_t coef_q;
	logic vld_s1;
	logic [COORD_W-1:0] col_s1, row_s1;
	logic lin_vld;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_w;
	logic vx, vy, zx, zy;
	logic signed [QUO_W-1:0] qx, qy;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Coefficient registers; writes beyond the register list are dropped.
	// After reset the map is the identity: a and e are one, all else zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= coef_t'({ONE_Q16, {3{32'h0}}, ONE_Q16, {3{32'h0}}});
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_A:  coef_q.a <= cfg_data;
				REG_COEF_B:  coef_q.b <= cfg_data;
				REG_COEF_C:  coef_q.c <= cfg_data;
				REG_COEF_D:  coef_q.d <= cfg_data;
				REG_COEF_E:  coef_q.e <= cfg_data;
				REG_COEF_F:  coef_q.f <= cfg_data;
				REG_PERSP_G: coef_q.g <= cfg_data;
				REG_PERSP_H: coef_q.h <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: clamp the coordinates to the image size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= (pix_col > COORD_LIM) ? COORD_LIM : pix_col;
		row_s1 <= (pix_row > COORD_LIM) ? COORD_LIM : pix_row;
	end

	ppm_lin u_lin (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.col     (col_s1),
		.row     (row_s1),
		.coef    (coef_q),
		.out_vld (lin_vld),
		.sum_x   (sum_x),
		.sum_y   (sum_y),
		.sum_w   (sum_w)
	);

	// Both dividers share the denominator, so their flags agree.
	ppm_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (lin_vld),
		.num      (sum_x),
		.den      (sum_w),
		.out_vld  (vx),
		.quo      (qx),
		.den_zero (zx)
	);

	ppm_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (lin_vld),
		.num      (sum_y),
		.den      (sum_w),
		.out_vld  (vy),
		.quo      (qy),
		.den_zero (zy)
	);

	assign done   = vx & vy;
	assign map_x  = qx;
	assign map_y  = qy;
	assign w_zero = zx | zy;

endmodule
